[rtl/core/swird_pkg.sv]
`default_nettype none
package swird_pkg;

  // Configuration port.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 12;

  localparam logic [CFG_INDEX_W-1:0] CFG_ROW_PIXELS     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ROWS_PER_FRAME = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_BYTES   = 2'd2;

  localparam logic [11:0] ROW_PIXELS_RESET     = 12'd640;
  localparam logic [11:0] ROWS_PER_FRAME_RESET = 12'd512;
  localparam logic [6:0]  HEADER_BYTES_RESET   = 7'd12;

  // Header length limits, including the sync word.
  localparam logic [6:0] HDR_LEN_MIN = 7'd12;
  localparam logic [6:0] HDR_LEN_MAX = 7'd64;

  // Header byte positions.
  localparam logic [5:0] HDR_SYNC_LEN   = 6'd4;
  localparam logic [5:0] HDR_ROW_LO     = 6'd8;
  localparam logic [5:0] HDR_ROW_HI     = 6'd9;
  localparam logic [5:0] HDR_FRAME_LO   = 6'd10;
  localparam logic [5:0] HDR_FRAME_HI   = 6'd11;

  // Sync word 90 EB 00 00.
  localparam logic [7:0] SYNC_BYTE0 = 8'h90;
  localparam logic [7:0] SYNC_BYTE1 = 8'hEB;
  localparam logic [7:0] SYNC_ZERO  = 8'h00;

  // Width of clamped pixel and row counts (holds up to 8191).
  localparam int CLAMP_W = 13;

  // Parameter defaults.
  localparam int MAX_WIDTH_DEFAULT   = 2048;
  localparam int MAX_HEIGHT_DEFAULT  = 2048;
  localparam int PIXEL_BYTES_DEFAULT = 2;

  // Depth of the queue between parser and output stage.
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_HEAD = 2'd1,
    PH_LOAD = 2'd2
  } phase_t;

  typedef enum logic {
    EV_HEADER = 1'b0,
    EV_PIXEL  = 1'b1
  } ev_kind_t;

  typedef struct packed {
    logic [11:0] row_pixels;
    logic [11:0] rows_per_frame;
    logic [6:0]  header_bytes;
  } cfg_t;

  // One parsed event. For a header event, value carries the frame number.
  typedef struct packed {
    ev_kind_t    kind;
    logic        frame_end;
    logic [10:0] row;
    logic [10:0] col;
    logic [15:0] value;
  } event_t;

  typedef struct packed {
    logic        pixel_valid;
    logic [10:0] row_index;
    logic [10:0] column_index;
    logic [15:0] pixel_value;
    logic        frame_ready;
    logic [15:0] ready_frame_number;
  } result_t;

endpackage
`default_nettype wire

[rtl/core/sync_word_image_row_deframer.sv]
// Sync-word image row deframer.
// The input channel takes one raw byte per word: a byte is accepted at a clock edge
// where in_push is high and in_full is low. The parser hunts for the sync word
// 90 EB 00 00, reads a header whose bytes 8-9 hold the row number and 10-11 the
// frame number, then takes one row of pixels. Each pixel of a row in 1..height
// becomes a result word with its row and column; a result word with frame_ready
// set publishes a frame on the last row or when the frame number changes.
// Results are read as from a queue: a word is waiting while out_empty is low and
// is taken at an edge where out_pop is high.
// Throughput is one byte per cycle while in_full is low. The parser writes the
// event queue at the edge that accepts a byte; the output register takes the event
// from the queue once the register is empty or being popped. A stalled receiver
// fills the four-entry event queue, after which in_full rises until words are
// popped again.
// Configuration words (cfg_valid; cfg_ready is always high) take effect at the next
// byte and are meant to be written only while no result word is in flight.
// Synchronous reset returns the parser to sync hunting, empties the queue, clears
// the frame bookkeeping and restores the register defaults (640 pixels per row,
// 512 rows per frame, 12 header bytes).
`default_nettype none
module sync_word_image_row_deframer #(
  parameter int MAX_WIDTH   = swird_pkg::MAX_WIDTH_DEFAULT,
  parameter int MAX_HEIGHT  = swird_pkg::MAX_HEIGHT_DEFAULT,
  parameter int PIXEL_BYTES = swird_pkg::PIXEL_BYTES_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [swird_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [swird_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                             in_push,
  output logic                                  in_full,
  input  wire logic [7:0]                       in_data_byte,
  output logic                                  out_empty,
  input  wire logic                             out_pop,
  output logic                                  out_pixel_valid,
  output logic [10:0]                           out_row_index,
  output logic [10:0]                           out_column_index,
  output logic [15:0]                           out_pixel_value,
  output logic                                  out_frame_ready,
  output logic [15:0]                           out_ready_frame_number
);
  import swird_pkg::*;

  cfg_t    cfg_r, cfg_nxt;
  event_t  fr_ev, q_ev;
  logic    fr_push, q_full, q_empty, q_pop;
  logic    out_valid;
  result_t res;

  // Configuration registers; writes beyond the register list are dropped.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ROW_PIXELS:     cfg_nxt.row_pixels     = cfg_data;
        CFG_ROWS_PER_FRAME: cfg_nxt.rows_per_frame = cfg_data;
        CFG_HEADER_BYTES:   cfg_nxt.header_bytes   = cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.row_pixels     <= ROW_PIXELS_RESET;
      cfg_r.rows_per_frame <= ROWS_PER_FRAME_RESET;
      cfg_r.header_bytes   <= HEADER_BYTES_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front: byte parser that turns the stream into header and pixel events.
  swird_front #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .PIXEL_BYTES (PIXEL_BYTES)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_push      (in_push),
    .in_data_byte (in_data_byte),
    .in_full      (in_full),
    .ev_push      (fr_push),
    .ev           (fr_ev),
    .q_full       (q_full)
  );

  // Short event queue so the parser keeps running while the receiver stalls.
  swird_queue #(
    .WIDTH ($bits(event_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (fr_push),
    .wr_data (fr_ev),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_ev),
    .empty   (q_empty)
  );

  // Back: frame bookkeeping and the output register.
  swird_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_ev      (q_ev),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_valid (out_valid),
    .res       (res)
  );

  assign out_empty              = ~out_valid;
  assign out_pixel_valid        = res.pixel_valid;
  assign out_row_index          = res.row_index;
  assign out_column_index       = res.column_index;
  assign out_pixel_value        = res.pixel_value;
  assign out_frame_ready        = res.frame_ready;
  assign out_ready_frame_number = res.ready_frame_number;

endmodule
`default_nettype wire

[rtl/core/swird_queue.sv]
`default_nettype none
module swird_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);
  assign rd_data = mem_r[rd_ptr_r];
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

[rtl/core/swird_front.sv]
`default_nettype none
module swird_front #(
  parameter int MAX_WIDTH   = swird_pkg::MAX_WIDTH_DEFAULT,
  parameter int MAX_HEIGHT  = swird_pkg::MAX_HEIGHT_DEFAULT,
  parameter int PIXEL_BYTES = swird_pkg::PIXEL_BYTES_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire swird_pkg::cfg_t   cfg,
  input  wire logic              in_push,
  input  wire logic [7:0]        in_data_byte,
  output logic                   in_full,
  output logic                   ev_push,
  output swird_pkg::event_t      ev,
  input  wire logic              q_full
);
  import swird_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam logic [CLAMP_W-1:0] MAX_W_C = CLAMP_W'(MAX_WIDTH);
  localparam logic [CLAMP_W-1:0] MAX_H_C = CLAMP_W'(MAX_HEIGHT);

  phase_t           phase_r, phase_nxt;
  logic [1:0]       sync_r, sync_nxt;
  logic [5:0]       pos_r, pos_nxt;
  logic [15:0]      row_r, row_nxt;
  logic [15:0]      frame_r, frame_nxt;
  logic [7:0]       asm_r, asm_nxt;
  logic             bip_r, bip_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic             in_range_r, in_range_nxt;

  logic               accept;
  logic [6:0]         hlen;
  logic [CLAMP_W-1:0] npix, nrows, rp, rf;
  logic [7:0]         want;
  logic [15:0]        pix;
  logic               last;

  assign in_full = q_full;
  assign accept  = in_push & ~q_full;

  // Clamped register values.
  always_comb begin
    rp = {1'b0, cfg.row_pixels};
    rf = {1'b0, cfg.rows_per_frame};
    if (cfg.header_bytes < HDR_LEN_MIN) begin
      hlen = HDR_LEN_MIN;
    end else if (cfg.header_bytes > HDR_LEN_MAX) begin
      hlen = HDR_LEN_MAX;
    end else begin
      hlen = cfg.header_bytes;
    end
    if (rp == '0) begin
      npix = CLAMP_W'(1);
    end else if (rp > MAX_W_C) begin
      npix = MAX_W_C;
    end else begin
      npix = rp;
    end
    if (rf == '0) begin
      nrows = CLAMP_W'(1);
    end else if (rf > MAX_H_C) begin
      nrows = MAX_H_C;
    end else begin
      nrows = rf;
    end
  end

  always_comb begin
    phase_nxt    = phase_r;
    sync_nxt     = sync_r;
    pos_nxt      = pos_r;
    row_nxt      = row_r;
    frame_nxt    = frame_r;
    asm_nxt      = asm_r;
    bip_nxt      = bip_r;
    col_nxt      = col_r;
    in_range_nxt = in_range_r;
    ev_push      = 1'b0;
    ev           = '0;
    want         = SYNC_ZERO;
    pix          = '0;
    last         = 1'b0;
    if (accept) begin
      unique case (phase_r)
        PH_HEAD: begin
          case (pos_r)
            HDR_ROW_LO:   row_nxt[7:0]    = in_data_byte;
            HDR_ROW_HI:   row_nxt[15:8]   = in_data_byte;
            HDR_FRAME_LO: frame_nxt[7:0]  = in_data_byte;
            HDR_FRAME_HI: frame_nxt[15:8] = in_data_byte;
            default: ;
          endcase
          if (({1'b0, pos_r} + 7'd1) < hlen) begin
            pos_nxt = pos_r + 6'd1;
          end else begin
            phase_nxt    = PH_LOAD;
            pos_nxt      = '0;
            col_nxt      = '0;
            bip_nxt      = 1'b0;
            asm_nxt      = '0;
            in_range_nxt = (row_nxt != '0) && (row_nxt <= 16'(nrows));
            // The output stage decides whether the frame number changed.
            ev_push      = 1'b1;
            ev.kind      = EV_HEADER;
            ev.value     = frame_nxt;
          end
        end
        PH_LOAD: begin
          if (PIXEL_BYTES == 2 && !bip_r) begin
            asm_nxt = in_data_byte;
            bip_nxt = 1'b1;
          end else begin
            pix     = (PIXEL_BYTES == 2) ? {in_data_byte, asm_r} : {8'h00, in_data_byte};
            bip_nxt = 1'b0;
            last    = (CLAMP_W'(col_r) + CLAMP_W'(1)) >= npix;
            col_nxt = col_r + 1'b1;
            if (last) begin
              phase_nxt = PH_HUNT;
              sync_nxt  = '0;
              col_nxt   = '0;
            end
            if (in_range_r) begin
              ev_push      = 1'b1;
              ev.kind      = EV_PIXEL;
              ev.frame_end = last && (row_r == 16'(nrows));
              ev.row       = 11'(row_r - 16'd1);
              ev.col       = 11'(col_r);
              ev.value     = pix;
            end
          end
        end
        default: begin
          // Sync hunt; an unused phase code also lands here.
          phase_nxt = PH_HUNT;
          unique case (sync_r)
            2'd0:    want = SYNC_BYTE0;
            2'd1:    want = SYNC_BYTE1;
            default: want = SYNC_ZERO;
          endcase
          if (in_data_byte == want) begin
            if (sync_r == 2'd3) begin
              sync_nxt  = '0;
              phase_nxt = PH_HEAD;
              pos_nxt   = HDR_SYNC_LEN;
            end else begin
              sync_nxt = sync_r + 2'd1;
            end
          end else begin
            sync_nxt = (in_data_byte == SYNC_BYTE0) ? 2'd1 : 2'd0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HUNT;
      sync_r     <= '0;
      pos_r      <= '0;
      row_r      <= '0;
      frame_r    <= '0;
      asm_r      <= '0;
      bip_r      <= 1'b0;
      col_r      <= '0;
      in_range_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      sync_r     <= sync_nxt;
      pos_r      <= pos_nxt;
      row_r      <= row_nxt;
      frame_r    <= frame_nxt;
      asm_r      <= asm_nxt;
      bip_r      <= bip_nxt;
      col_r      <= col_nxt;
      in_range_r <= in_range_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/core/swird_back.sv]
`default_nettype none
module swird_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire swird_pkg::event_t q_ev,
  input  wire logic              q_empty,
  output logic                   q_pop,
  input  wire logic              out_pop,
  output logic                   out_valid,
  output swird_pkg::result_t     res
);
  import swird_pkg::*;

  logic        out_valid_r, out_valid_nxt;
  result_t     res_r, res_nxt;
  logic [15:0] active_r, active_nxt;
  logic        known_r, known_nxt;
  logic [15:0] pub_r, pub_nxt;
  logic        pub_known_r, pub_known_nxt;

  logic        take;
  logic        produce;
  logic [15:0] cur;

  assign take      = ~q_empty & (~out_valid_r | out_pop);
  assign q_pop     = take;
  assign out_valid = out_valid_r;
  assign res       = res_r;

  always_comb begin
    active_nxt    = active_r;
    known_nxt     = known_r;
    pub_nxt       = pub_r;
    pub_known_nxt = pub_known_r;
    res_nxt       = res_r;
    produce       = 1'b0;
    cur           = known_r ? active_r : q_ev.value;
    if (take) begin
      case (q_ev.kind)
        EV_HEADER: begin
          // The first frame seen becomes active; a change publishes the old
          // frame unless it was already published.
          known_nxt  = 1'b1;
          active_nxt = q_ev.value;
          if (q_ev.value != cur && !(pub_known_r && pub_r == cur)) begin
            pub_nxt       = cur;
            pub_known_nxt = 1'b1;
            produce       = 1'b1;
            res_nxt       = '0;
            res_nxt.frame_ready        = 1'b1;
            res_nxt.ready_frame_number = cur;
          end
        end
        default: begin
          produce              = 1'b1;
          res_nxt              = '0;
          res_nxt.pixel_valid  = 1'b1;
          res_nxt.row_index    = q_ev.row;
          res_nxt.column_index = q_ev.col;
          res_nxt.pixel_value  = q_ev.value;
          if (q_ev.frame_end) begin
            pub_nxt                    = active_r;
            pub_known_nxt              = 1'b1;
            res_nxt.frame_ready        = 1'b1;
            res_nxt.ready_frame_number = active_r;
          end
        end
      endcase
    end
    out_valid_nxt = take ? produce : (out_valid_r & ~out_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      active_r    <= '0;
      known_r     <= 1'b0;
      pub_r       <= '0;
      pub_known_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      active_r    <= active_nxt;
      known_r     <= known_nxt;
      pub_r       <= pub_nxt;
      pub_known_r <= pub_known_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule
`default_nettype wire
